// File: hdl/vector_normalize_macros.svh
// assertion helpers for the vector normalize block
// all of them sample on clk; the first two are off while rst_n is low
`ifndef VECTOR_NORMALIZE_MACROS_SVH
`define VECTOR_NORMALIZE_MACROS_SVH

// condition holds in the same cycle
`define VN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector_normalize check failed");

// condition holds in the next cycle
`define VN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector_normalize check failed");

// checked also while reset is applied
`define VN_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vector_normalize reset check failed");

`endif

// File: hdl/vn_pkg.sv
`default_nettype none

package vn_pkg;

  localparam int NUM_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_Z    = 2;

  localparam logic DIM3_RESET = 1'b1;

  // side info that travels with each word down the pipe
  typedef struct packed {
    logic                 zero;
    logic [NUM_LANES-1:0] neg;
  } vn_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/vn_prep.sv
`default_nettype none

module vn_prep import vn_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           in_valid,
  output logic                                                in_ready,
  input  wire logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]       vec,
  input  wire logic                                           dim3,
  output logic                                                out_valid,
  input  wire logic                                           out_ready,
  output logic [2*COMPONENT_BITS-1:0]                         sum_sq,
  output logic [NUM_LANES-1:0][2*COMPONENT_BITS-2:0]          mag_sq,
  output vn_ctrl_t                                            ctrl
);

  localparam int CB  = COMPONENT_BITS;
  localparam int SQW = 2 * CB - 1;
  localparam int SW  = 2 * CB;

  // stage a: capture, z masked in 2-d mode
  logic                            va_r;
  logic                            ready_a;
  logic [NUM_LANES-1:0][CB-1:0]    raw_r;
  logic [NUM_LANES-1:0][CB-1:0]    raw_nxt;

  // stage b: magnitude and square
  logic                            vb_r;
  logic                            ready_b;
  logic [NUM_LANES-1:0][SQW-1:0]   sq_b_r;
  logic [NUM_LANES-1:0][SQW-1:0]   sq_b_nxt;
  logic [NUM_LANES-1:0]            neg_b_r;
  logic [NUM_LANES-1:0]            neg_b_nxt;
  logic [NUM_LANES-1:0][CB-1:0]    mag;
  logic [NUM_LANES-1:0][SW-1:0]    prod;

  // stage c: sum of squares
  logic                            vc_r;
  logic                            ready_c;
  logic [SW-1:0]                   sum_r;
  logic [SW-1:0]                   sum_nxt;
  logic [NUM_LANES-1:0][SQW-1:0]   sq_c_r;
  vn_ctrl_t                        ctrl_r;
  vn_ctrl_t                        ctrl_nxt;

  assign ready_c  = !vc_r || out_ready;
  assign ready_b  = !vb_r || ready_c;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    raw_nxt         = vec;
    raw_nxt[LANE_Z] = dim3 ? vec[LANE_Z] : '0;
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      neg_b_nxt[l] = raw_r[l][CB-1];
      mag[l]       = neg_b_nxt[l] ? (~raw_r[l] + CB'(1)) : raw_r[l];
      prod[l]      = mag[l] * mag[l];
      sq_b_nxt[l]  = prod[l][SQW-1:0];
    end
  end

  always_comb begin
    sum_nxt       = SW'(sq_b_r[LANE_X]) + SW'(sq_b_r[LANE_Y]) + SW'(sq_b_r[LANE_Z]);
    ctrl_nxt.zero = (sum_nxt == '0);
    ctrl_nxt.neg  = neg_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
      if (ready_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      raw_r <= raw_nxt;
    end
    if (ready_b && va_r) begin
      sq_b_r  <= sq_b_nxt;
      neg_b_r <= neg_b_nxt;
    end
    if (ready_c && vb_r) begin
      sum_r  <= sum_nxt;
      sq_c_r <= sq_b_r;
      ctrl_r <= ctrl_nxt;
    end
  end

  assign out_valid = vc_r;
  assign sum_sq    = sum_r;
  assign mag_sq    = sq_c_r;
  assign ctrl      = ctrl_r;

endmodule

`default_nettype wire

// File: hdl/vn_cell.sv
`default_nettype none

// decides one result bit for every lane:
// keeps p = (2r-1)*s and q = (2r-1)^2*s so that trying a bit needs only shifts and adds
module vn_cell import vn_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14,
  parameter int BIT_POS        = 14
) (
  input  wire logic                                                              clk,
  input  wire logic                                                              rst_n,
  input  wire logic                                                              in_valid,
  output logic                                                                   in_ready,
  output logic                                                                   out_valid,
  input  wire logic                                                              out_ready,
  input  wire logic [2*COMPONENT_BITS-1:0]                                       s_i,
  output logic [2*COMPONENT_BITS-1:0]                                            s_o,
  input  wire logic [NUM_LANES-1:0][2*COMPONENT_BITS-2:0]                        m2_i,
  output logic [NUM_LANES-1:0][2*COMPONENT_BITS-2:0]                             m2_o,
  input  wire vn_ctrl_t                                                          ctrl_i,
  output vn_ctrl_t                                                               ctrl_o,
  input  wire logic [NUM_LANES-1:0][FRACTION_BITS:0]                             r_i,
  output logic [NUM_LANES-1:0][FRACTION_BITS:0]                                  r_o,
  input  wire logic [NUM_LANES-1:0][2*COMPONENT_BITS+2*FRACTION_BITS+3:0]        p_i,
  output logic [NUM_LANES-1:0][2*COMPONENT_BITS+2*FRACTION_BITS+3:0]             p_o,
  input  wire logic [NUM_LANES-1:0][2*COMPONENT_BITS+2*FRACTION_BITS+3:0]        q_i,
  output logic [NUM_LANES-1:0][2*COMPONENT_BITS+2*FRACTION_BITS+3:0]             q_o
);

  localparam int RW  = FRACTION_BITS + 1;
  localparam int SW  = 2 * COMPONENT_BITS;
  localparam int SQW = 2 * COMPONENT_BITS - 1;
  localparam int W   = 2 * COMPONENT_BITS + 2 * FRACTION_BITS + 4;

  logic                            valid_r;
  logic [SW-1:0]                   s_r;
  logic [NUM_LANES-1:0][SQW-1:0]   m2_r;
  vn_ctrl_t                        ctrl_r;
  logic [NUM_LANES-1:0][RW-1:0]    r_r;
  logic [NUM_LANES-1:0][W-1:0]     p_r;
  logic [NUM_LANES-1:0][W-1:0]     q_r;

  logic [NUM_LANES-1:0][RW-1:0]    r_nxt;
  logic [NUM_LANES-1:0][W-1:0]     p_nxt;
  logic [NUM_LANES-1:0][W-1:0]     q_nxt;
  logic [W-1:0]                    s_ext;
  logic signed [W-1:0]             q_cand [NUM_LANES];
  logic signed [W-1:0]             m_big  [NUM_LANES];
  logic [NUM_LANES-1:0]            take;

  assign in_ready = !valid_r || out_ready;
  assign s_ext    = {{(W-SW){1'b0}}, s_i};

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      q_cand[l] = $signed(q_i[l]) + ($signed(p_i[l]) <<< (BIT_POS + 2))
                + $signed(s_ext << (2 * BIT_POS + 2));
      m_big[l]  = $signed({{(W-SQW){1'b0}}, m2_i[l]} << (2 * FRACTION_BITS + 2));
      // once the top bit is set the result is already full scale
      take[l]   = !r_i[l][RW-1] && (q_cand[l] <= m_big[l]);
      r_nxt[l]  = take[l] ? (r_i[l] | (RW'(1) << BIT_POS)) : r_i[l];
      q_nxt[l]  = take[l] ? q_cand[l] : q_i[l];
      p_nxt[l]  = take[l] ? (p_i[l] + (s_ext << (BIT_POS + 1))) : p_i[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_r    <= s_i;
      m2_r   <= m2_i;
      ctrl_r <= ctrl_i;
      r_r    <= r_nxt;
      p_r    <= p_nxt;
      q_r    <= q_nxt;
    end
  end

  assign out_valid = valid_r;
  assign s_o       = s_r;
  assign m2_o      = m2_r;
  assign ctrl_o    = ctrl_r;
  assign r_o       = r_r;
  assign p_o       = p_r;
  assign q_o       = q_r;

endmodule

`default_nettype wire

// File: hdl/vector_normalize.sv
// vector normalize: scales a 2-d or 3-d integer vector to unit length, signed q1.14
//
// in_*  : stream of vectors, one word per accepted handshake (x, y, z)
// out_* : stream of normalized vectors (x, y, z) with the zero-vector flag in out_tuser
// cfg_* : one-bit dimension select, 1 = x,y,z and 0 = x,y only (z result then 0);
//         always ready, change it only while no word is in flight
//
// the pipe has registered stages for capture, squaring and the sum of squares,
// one cell per result bit and one output register. a new word can be accepted
// every cycle unless the pipe is full and out_tready is low: every stage has its
// own valid bit and takes a word when it is empty or its successor moves on, so
// the pipe keeps filling bubbles while out_tready is low and stops only when full.
// a zero vector gives all-zero components with the flag set.
//
// rst_n (synchronous, active low) empties the pipe and sets 3-d mode.
`default_nettype none

module vector_normalize import vn_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input  wire logic                                               clk,
  input  wire logic                                               rst_n,
  input  wire logic                                               cfg_valid,
  output logic                                                    cfg_ready,
  input  wire logic                                               cfg_data,
  input  wire logic                                               in_tvalid,
  output logic                                                    in_tready,
  // vec_x, vec_y, vec_z from bit 0 up, zero padded to bytes
  input  wire logic [((NUM_LANES*COMPONENT_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                                    out_tvalid,
  input  wire logic                                               out_tready,
  // norm_x, norm_y, norm_z from bit 0 up, zero padded to bytes
  output logic [((NUM_LANES*(FRACTION_BITS+2)+7)/8)*8-1:0]        out_tdata,
  // zero_vector
  output logic [0:0]                                              out_tuser
);

  localparam int CB  = COMPONENT_BITS;
  localparam int FB  = FRACTION_BITS;
  localparam int RW  = FB + 1;
  localparam int NW  = FB + 2;
  localparam int SW  = 2 * CB;
  localparam int SQW = 2 * CB - 1;
  localparam int W   = 2 * CB + 2 * FB + 4;
  localparam int NC  = FB + 1;

  logic dim3_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim3_r <= DIM3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim3_r <= cfg_data;
    end
  end

  logic [NUM_LANES-1:0][CB-1:0] vec;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      vec[l] = in_tdata[l*CB +: CB];
    end
  end

  // chain of cells, position 0 is fed by the front end
  logic                            c_valid [NC+1];
  logic                            c_ready [NC+1];
  logic [SW-1:0]                   c_s     [NC+1];
  logic [NUM_LANES-1:0][SQW-1:0]   c_m2    [NC+1];
  vn_ctrl_t                        c_ctrl  [NC+1];
  logic [NUM_LANES-1:0][RW-1:0]    c_r     [NC+1];
  logic [NUM_LANES-1:0][W-1:0]     c_p     [NC+1];
  logic [NUM_LANES-1:0][W-1:0]     c_q     [NC+1];

  vn_prep #(
    .COMPONENT_BITS(CB)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .vec      (vec),
    .dim3     (dim3_r),
    .out_valid(c_valid[0]),
    .out_ready(c_ready[0]),
    .sum_sq   (c_s[0]),
    .mag_sq   (c_m2[0]),
    .ctrl     (c_ctrl[0])
  );

  // start of the search: r = 0, so 2r-1 = -1
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_start
    assign c_r[0][l] = '0;
    assign c_q[0][l] = {{(W-SW){1'b0}}, c_s[0]};
    assign c_p[0][l] = '0 - {{(W-SW){1'b0}}, c_s[0]};
  end

  for (genvar k = 0; k < NC; k++) begin : g_chain
    vn_cell #(
      .COMPONENT_BITS(CB),
      .FRACTION_BITS (FB),
      .BIT_POS       (FB - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (c_valid[k]),
      .in_ready (c_ready[k]),
      .out_valid(c_valid[k+1]),
      .out_ready(c_ready[k+1]),
      .s_i      (c_s[k]),
      .s_o      (c_s[k+1]),
      .m2_i     (c_m2[k]),
      .m2_o     (c_m2[k+1]),
      .ctrl_i   (c_ctrl[k]),
      .ctrl_o   (c_ctrl[k+1]),
      .r_i      (c_r[k]),
      .r_o      (c_r[k+1]),
      .p_i      (c_p[k]),
      .p_o      (c_p[k+1]),
      .q_i      (c_q[k]),
      .q_o      (c_q[k+1])
    );
  end

  // output register: apply sign, force zero for a zero vector
  logic                            out_valid_r;
  logic [NUM_LANES-1:0][NW-1:0]    norm_r;
  logic [NUM_LANES-1:0][NW-1:0]    norm_nxt;
  logic                            zero_r;
  logic [NUM_LANES-1:0][NW-1:0]    mag_ext;

  assign c_ready[NC] = !out_valid_r || out_tready;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag_ext[l] = {1'b0, c_r[NC][l]};
      if (c_ctrl[NC].zero) begin
        norm_nxt[l] = '0;
      end else if (c_ctrl[NC].neg[l]) begin
        norm_nxt[l] = '0 - mag_ext[l];
      end else begin
        norm_nxt[l] = mag_ext[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_ready[NC]) begin
      out_valid_r <= c_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[NC] && c_valid[NC]) begin
      norm_r <= norm_nxt;
      zero_r <= c_ctrl[NC].zero;
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      out_tdata[l*NW +: NW] = norm_r[l];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = zero_r;

endmodule

`default_nettype wire

// File: hdl/vn_checker.sv
`default_nettype none
`include "vector_normalize_macros.svh"

module vn_checker import vn_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input wire logic                                                clk,
  input wire logic                                                rst_n,
  input wire logic                                                out_tvalid,
  input wire logic                                                out_tready,
  input wire logic [((NUM_LANES*(FRACTION_BITS+2)+7)/8)*8-1:0]    out_tdata,
  input wire logic [0:0]                                          out_tuser
);

  localparam int NW = FRACTION_BITS + 2;
  localparam logic signed [NW-1:0] ONE     = NW'(1) << FRACTION_BITS;
  localparam logic signed [NW-1:0] NEG_ONE = '0 - (NW'(1) << FRACTION_BITS);

  logic signed [NW-1:0] lane_val [NUM_LANES];

  // a stalled result is held
  `VN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // zero vector flag comes with all-zero components
  `VN_ASSERT_NOW(a_zero_data, out_tvalid && out_tuser[0], out_tdata == '0)

  // reset empties the pipe
  `VN_ASSERT_RESET(a_reset_empty, !rst_n, !out_tvalid)

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_val[g] = out_tdata[g*NW +: NW];
    // a unit vector component never exceeds one
    `VN_ASSERT_NOW(a_unit_range, out_tvalid, (lane_val[g] <= ONE) && (lane_val[g] >= NEG_ONE))
  end

endmodule

bind vector_normalize vn_checker #(
  .COMPONENT_BITS(COMPONENT_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_vn_checker (.*);

`default_nettype wire
